// ===== hdl/bb3_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and the rounded-mean divider for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int FIFO_DEPTH = 4;

	localparam logic [10:0] WIDTH_RESET  = 11'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	// Reciprocals for the divisions by 6 and by 18.
	localparam logic [13:0] RECIP_6  = 14'd10923;
	localparam logic [12:0] RECIP_18 = 13'd7282;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		NB_4 = 2'd0,
		NB_6 = 2'd1,
		NB_9 = 2'd2
	} nb_count_t;

	typedef logic [23:0] px_t;

	// One classified input: the 3x3 view and which results it completes.
	// emit[0]: (r-1,c-1), emit[1]: (r-1,c), emit[2]: (r,c-1), emit[3]: (r,c).
	typedef struct packed {
		px_t [2:0][2:0] view;
		logic [11:0]    row;
		logic [9:0]     col;
		logic           row_ge2;
		logic           col_ge2;
		logic [3:0]     emit;
	} job_t;

	// floor((2*sum+N)/(2N)) for N of 4, 6 or 9.
	function automatic logic [7:0] mean(logic [11:0] s, nb_count_t n);
		logic [12:0] x;
		logic [26:0] p;
		logic [7:0]  q;
		x = '0;
		p = '0;
		q = '0;
		unique case (n)
			NB_4: begin
				x = 13'(s) + 13'd2;
				q = x[9:2];
			end
			NB_6: begin
				x = 13'(s) + 13'd3;
				p = 27'(x) * 27'(RECIP_6);
				q = p[23:16];
			end
			NB_9: begin
				x = {s, 1'b0} + 13'd9;
				p = 27'(x) * 27'(RECIP_18);
				q = p[24:17];
			end
			default: q = '0;
		endcase
		return q;
	endfunction

endpackage

// ===== hdl/bb3_if.sv =====
// ----------------------------------------------------------------------------
// bb3_if
// Valid/ready channels for input pixels and blurred results.
// ----------------------------------------------------------------------------
interface bb3_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	modport source(output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink(input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

interface bb3_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic        run_last;
	logic        frame_last;
	modport source(output valid, output out_red, output out_green, output out_blue,
		output out_row, output out_col, output run_last, output frame_last,
		input ready);
	modport sink(input valid, input out_red, input out_green, input out_blue,
		input out_row, input out_col, input run_last, input frame_last,
		output ready);
endinterface

// ===== hdl/bb3_front.sv =====
// ----------------------------------------------------------------------------
// bb3_front
// Tracks the raster position, reads the line store and the window, and hands
// each pixel that completes results to the queue as a job.
// ----------------------------------------------------------------------------
module bb3_front (
	input  logic              clk,
	input  logic              arst_n,
	bb3_pix_if.sink           pix,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [12:0]       cfg_data,
	output bb3_pkg::job_t     job,
	output logic              job_push,
	input  logic              job_full
);

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [10:0] w_eff;
	logic [12:0] h_eff;
	logic [9:0]  col_q;
	logic [11:0] row_q;
	logic [9:0]  c_eff;
	logic [11:0] r_eff;
	logic        last_col;
	logic        last_row;
	logic        accept;

	// Line store entry: [47:24] two rows up, [23:0] one row up.
	logic [47:0] line_mem [bb3_pkg::MAX_WIDTH];

	logic        v_s1;
	logic [47:0] rd_s1;
	bb3_pkg::px_t pix_s1;
	logic [9:0]  col_s1;
	logic [11:0] row_s1;
	logic        lc_s1;
	logic        lr_s1;
	logic        adv_s1;
	logic [3:0]  emit;

	bb3_pkg::px_t win_q [3][2];
	bb3_pkg::px_t col2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bb3_pkg::WIDTH_RESET;
			height_q <= bb3_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (bb3_pkg::reg_index_t'(cfg_index))
				bb3_pkg::REG_WIDTH:  width_q  <= cfg_data[10:0];
				bb3_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < 11'd2)
			w_eff = 11'd2;
		else if (width_q > 11'(bb3_pkg::MAX_WIDTH))
			w_eff = 11'(bb3_pkg::MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q < 13'd2)
			h_eff = 13'd2;
		else if (height_q > 13'(bb3_pkg::MAX_HEIGHT))
			h_eff = 13'(bb3_pkg::MAX_HEIGHT);
		else
			h_eff = height_q;
		// A count left beyond the size in use restarts at zero.
		c_eff = ({1'b0, col_q} >= w_eff) ? 10'd0 : col_q;
		r_eff = ({1'b0, row_q} >= h_eff) ? 12'd0 : row_q;
		last_col = ({1'b0, c_eff} == w_eff - 11'd1);
		last_row = ({1'b0, r_eff} == h_eff - 13'd1);
	end

	assign emit[0] = (row_s1 != 12'd0) && (col_s1 != 10'd0);
	assign emit[1] = (row_s1 != 12'd0) && lc_s1;
	assign emit[2] = lr_s1 && (col_s1 != 10'd0);
	assign emit[3] = lr_s1 && lc_s1;

	assign adv_s1    = v_s1 && ((emit == 4'd0) || !job_full);
	assign pix.ready = !v_s1 || adv_s1;
	assign accept    = pix.valid && pix.ready;
	assign job_push  = adv_s1 && (emit != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? 12'd0 : r_eff + 12'd1;
				end else begin
					col_q <= c_eff + 10'd1;
					row_q <= r_eff;
				end
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1  <= line_mem[c_eff];
			pix_s1 <= {pix.in_red, pix.in_green, pix.in_blue};
			col_s1 <= c_eff;
			row_s1 <= r_eff;
			lc_s1  <= last_col;
			lr_s1  <= last_row;
		end
		if (adv_s1)
			line_mem[col_s1] <= {rd_s1[23:0], pix_s1};
	end

	assign col2[0] = rd_s1[47:24];
	assign col2[1] = rd_s1[23:0];
	assign col2[2] = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= '0;
				win_q[k][1] <= '0;
			end
		end else if (adv_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= col2[k];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			job.view[k][0] = win_q[k][0];
			job.view[k][1] = win_q[k][1];
			job.view[k][2] = col2[k];
		end
		job.row     = row_s1;
		job.col     = col_s1;
		job.row_ge2 = (row_s1 >= 12'd2);
		job.col_ge2 = (col_s1 >= 10'd2);
		job.emit    = emit;
	end

endmodule

// ===== hdl/bb3_fifo.sv =====
// ----------------------------------------------------------------------------
// bb3_fifo
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module bb3_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bb3_pkg::job_t din,
	input  logic          pop,
	output bb3_pkg::job_t dout,
	output logic          empty,
	output logic          full
);

	localparam int AW = $clog2(bb3_pkg::FIFO_DEPTH);

	bb3_pkg::job_t mem_q [bb3_pkg::FIFO_DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (AW+1)'(bb3_pkg::FIFO_DEPTH));
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

endmodule

// ===== hdl/bb3_back.sv =====
// ----------------------------------------------------------------------------
// bb3_back
// Issues a queued job's results one per cycle unless the output stalls: a sum
// stage, then the divide by the neighbour count into the output register.
// ----------------------------------------------------------------------------
module bb3_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bb3_pkg::job_t job,
	input  logic          job_empty,
	output logic          job_pop,
	bb3_res_if.source     res
);

	logic [3:0]  done_q;
	logic [3:0]  pending;
	logic [3:0]  sel;
	logic        last_pick;
	logic        issue;
	logic        en_s1;
	logic        en_out;
	logic [2:0]  rmask;
	logic [2:0]  cmask;
	logic [11:0] sum [3];
	bb3_pkg::nb_count_t ncnt;
	logic [11:0] orow;
	logic [9:0]  ocol;

	logic        v_s1;
	logic [11:0] sum_s1 [3];
	bb3_pkg::nb_count_t n_s1;
	logic [11:0] row_s1;
	logic [9:0]  col_s1;
	logic        rl_s1;
	logic        fl_s1;

	assign pending   = job.emit & ~done_q;
	assign sel       = pending & (~pending + 4'd1);
	assign last_pick = ((pending & ~sel) == 4'd0);
	assign en_out    = !res.valid || res.ready;
	assign en_s1     = !v_s1 || en_out;
	assign issue     = !job_empty && en_s1;
	assign job_pop   = issue && last_pick;

	always_comb begin
		// Rows above r-1 and columns left of c-1 exist only past the edge.
		if (sel[0] || sel[1]) begin
			rmask = {1'b1, 1'b1, job.row_ge2};
			orow  = job.row - 12'd1;
		end else begin
			rmask = 3'b110;
			orow  = job.row;
		end
		if (sel[0] || sel[2]) begin
			cmask = {1'b1, 1'b1, job.col_ge2};
			ocol  = job.col - 10'd1;
		end else begin
			cmask = 3'b110;
			ocol  = job.col;
		end
		if (rmask[0] && cmask[0])
			ncnt = bb3_pkg::NB_9;
		else if (rmask[0] || cmask[0])
			ncnt = bb3_pkg::NB_6;
		else
			ncnt = bb3_pkg::NB_4;
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					if (rmask[k] && cmask[j])
						sum[ch] = sum[ch] + 12'(job.view[k][j][8*(2-ch) +: 8]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= '0;
			v_s1      <= 1'b0;
			res.valid <= 1'b0;
		end else begin
			if (issue)
				done_q <= last_pick ? 4'd0 : (done_q | sel);
			if (en_s1)
				v_s1 <= issue;
			if (en_out)
				res.valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			for (int ch = 0; ch < 3; ch++)
				sum_s1[ch] <= sum[ch];
			n_s1   <= ncnt;
			row_s1 <= orow;
			col_s1 <= ocol;
			rl_s1  <= last_pick;
			fl_s1  <= sel[3];
		end
		if (en_out && v_s1) begin
			res.out_red    <= bb3_pkg::mean(sum_s1[0], n_s1);
			res.out_green  <= bb3_pkg::mean(sum_s1[1], n_s1);
			res.out_blue   <= bb3_pkg::mean(sum_s1[2], n_s1);
			res.out_row    <= row_s1;
			res.out_col    <= col_s1;
			res.run_last   <= rl_s1;
			res.frame_last <= fl_s1;
		end
	end

endmodule

// ===== hdl/box_blur_3x3_edge_normalized_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_normalized_core
// Path: front stage, job queue, sum stage, output register. Throughput: the
// back gives one result per cycle unless res stalls; a pixel per cycle while
// pixels yield at most one result, the job queue absorbing the edge bursts.
// Reset clears position, window and queue and sets the size registers to
// 640 by 480; the line store holds no reset and is always written before use.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_normalized_core (
	input  logic        clk,
	input  logic        arst_n,
	bb3_pix_if.sink     pix,
	bb3_res_if.source   res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	bb3_pkg::job_t job_in;
	bb3_pkg::job_t job_out;
	logic          push;
	logic          pop;
	logic          empty;
	logic          full;

	bb3_front u_front (
		.clk(clk), .arst_n(arst_n), .pix(pix),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.job(job_in), .job_push(push), .job_full(full)
	);

	bb3_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .din(job_in),
		.pop(pop), .dout(job_out), .empty(empty), .full(full)
	);

	bb3_back u_back (
		.clk(clk), .arst_n(arst_n), .job(job_out), .job_empty(empty),
		.job_pop(pop), .res(res)
	);

endmodule

// ===== hdl/bb3_checker.sv =====
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks on the result channel of the box blur core.
// ----------------------------------------------------------------------------
module bb3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [7:0]  red,
	input logic [11:0] row,
	input logic [9:0]  col,
	input logic        run_last,
	input logic        frame_last
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(red) && $stable(row) && $stable(col))
		else $error("result changed while stalled");

	// The final pixel of a frame is always the last result of its input.
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid && frame_last |-> run_last)
		else $error("frame end without run end");

	// The final pixel never sits at row or column zero.
	a_frame_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid && frame_last |-> row != 12'd0 && col != 10'd0)
		else $error("frame end at the first row or column");

endmodule

bind box_blur_3x3_edge_normalized_core bb3_checker u_bb3_checker (
	.clk(clk), .arst_n(arst_n), .valid(res.valid), .ready(res.ready),
	.red(res.out_red), .row(res.out_row), .col(res.out_col),
	.run_last(res.run_last), .frame_last(res.frame_last)
);
